// ----- hw/rtl/hse_pkg.sv -----
// hse_pkg: shared types and constants for the heap sort engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hse_pkg;
  localparam int unsigned KeyW = 64;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_A,
    CMD_RD_B,
    CMD_WR_A,
    CMD_WR_B,
    CMD_RD_OUT
  } cmd_e;

  // compare of two doubles as numbers, a > b; NaN unsupported
  function automatic logic dbl_gt(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    logic sa, sb;
    logic mag_gt, mag_lt, both_zero;
    sa = a[KeyW-1];
    sb = b[KeyW-1];
    mag_gt = a[KeyW-2:0] > b[KeyW-2:0];
    mag_lt = a[KeyW-2:0] < b[KeyW-2:0];
    both_zero = (a[KeyW-2:0] == '0) && (b[KeyW-2:0] == '0);
    if (both_zero) return 1'b0;
    if (!sa && sb) return 1'b1;
    if (sa && !sb) return 1'b0;
    if (!sa) return mag_gt;
    return mag_lt;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/hse_ram.sv -----
// hse_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hse_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/hse_datapath.sv -----
// hse_datapath: key store, two key registers and comparator.
// Depends on hse_pkg and hse_ram.
`timescale 1ns / 1ps
`default_nettype none
module hse_datapath import hse_pkg::*; #(
  parameter int unsigned Capacity = 64,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  wire logic            clk_i,
  input  wire cmd_e            cmd_i,
  input  wire logic [AW-1:0]   addr_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic            cap_a_i,
  input  wire logic            cap_b_i,
  output logic [KeyW-1:0]      a_o,
  output logic                 b_gt_a_o,
  output logic [KeyW-1:0]      rdata_o
);
  logic [KeyW-1:0] a_q, b_q, wdata;
  logic            we;

  always_comb begin
    we = 1'b0;
    wdata = key_i;
    case (cmd_i)
      CMD_LOAD: we = 1'b1;
      CMD_WR_A: begin we = 1'b1; wdata = a_q; end
      CMD_WR_B: begin we = 1'b1; wdata = b_q; end
      default: we = 1'b0;
    endcase
  end

  hse_ram #(.Width(KeyW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .addr_i, .wdata_i(wdata), .rdata_o
  );

  always_ff @(posedge clk_i) begin
    if (cap_a_i) a_q <= rdata_o;
    if (cap_b_i) b_q <= rdata_o;
  end

  assign a_o = a_q;
  assign b_gt_a_o = dbl_gt(b_q, a_q);
endmodule
`default_nettype wire

// ----- hw/rtl/hse_ctrl.sv -----
// hse_ctrl: load, heapsort sequencer and read-out state machine.
// Depends on hse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hse_ctrl import hse_pkg::*; #(
  parameter int unsigned Capacity = 64,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          last_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output logic               out_last_o,
  output logic               out_drop_o,
  output logic               out_sel_o,
  output cmd_e               cmd_o,
  output logic [AW-1:0]      addr_o,
  output logic               cap_a_o,
  output logic               cap_b_o,
  input  wire logic          b_gt_a_i
);
  typedef enum logic [3:0] {
    S_LOAD, S_NEXT, S_RD_TOP, S_CAP_TOP, S_RD_CH, S_CAP_CH, S_CMP,
    S_SW_RD_N, S_SW_RD_T, S_SW_CAP_T, S_SWAP_T, S_SWAP_C, S_OUT_RD, S_OUT_SHOW
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;    // keys held
  logic [CW-1:0] len_q;    // heap size
  logic [CW-1:0] node_q;   // sifting node
  logic [CW-1:0] top_q;    // current largest
  logic [CW-1:0] ch_q;     // child under test
  logic [CW-1:0] bld_q;    // build index (next node + 1)
  logic [CW-1:0] k_q;      // read-out index
  logic          build_q, drop_q, right_q, root_q;
  logic [CW:0]   left;

  assign in_ready_o = (state_q == S_LOAD);
  assign out_last_o = (k_q + 1'b1 == cnt_q);
  assign out_drop_o = drop_q;
  assign left = {node_q, 1'b1};

  always_comb begin
    cmd_o = CMD_NONE;
    addr_o = '0;
    cap_a_o = 1'b0;
    cap_b_o = 1'b0;
    out_valid_o = 1'b0;
    out_sel_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        addr_o = cnt_q[AW-1:0];
        if (in_valid_i && cnt_q != CW'(Capacity)) cmd_o = CMD_LOAD;
      end
      S_RD_TOP: begin cmd_o = CMD_RD_A; addr_o = top_q[AW-1:0]; end
      S_CAP_TOP: cap_a_o = 1'b1;
      S_RD_CH: begin cmd_o = CMD_RD_B; addr_o = ch_q[AW-1:0]; end
      S_CAP_CH: cap_b_o = 1'b1;
      // swap: A <- mem[node], B <- mem[top], then cross-write
      S_SW_RD_N: begin cmd_o = CMD_RD_A; addr_o = node_q[AW-1:0]; end
      S_SW_RD_T: begin cmd_o = CMD_RD_B; addr_o = top_q[AW-1:0]; cap_a_o = 1'b1; end
      S_SW_CAP_T: cap_b_o = 1'b1;
      S_SWAP_T: begin cmd_o = CMD_WR_B; addr_o = node_q[AW-1:0]; end
      S_SWAP_C: begin cmd_o = CMD_WR_A; addr_o = top_q[AW-1:0]; end
      S_OUT_RD: addr_o = k_q[AW-1:0];
      S_OUT_SHOW: begin out_valid_o = 1'b1; out_sel_o = 1'b1; addr_o = k_q[AW-1:0]; end
      default: cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q <= '0; len_q <= '0; node_q <= '0; top_q <= '0; ch_q <= '0;
      bld_q <= '0; k_q <= '0; build_q <= 1'b0; drop_q <= 1'b0; right_q <= 1'b0;
      root_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: if (in_valid_i) begin
          logic [CW-1:0] n;
          n = (cnt_q != CW'(Capacity)) ? cnt_q + 1'b1 : cnt_q;
          if (cnt_q == CW'(Capacity)) drop_q <= 1'b1;
          cnt_q <= n;
          if (last_i) begin
            len_q <= n;
            bld_q <= n >> 1;
            build_q <= 1'b1;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (build_q && bld_q != '0) begin
            node_q <= bld_q - 1'b1; top_q <= bld_q - 1'b1;
            bld_q <= bld_q - 1'b1;
            right_q <= 1'b0;
            state_q <= S_RD_TOP;
          end else if (len_q > CW'(1)) begin
            // swap root with last heap entry, then sift the root
            build_q <= 1'b0;
            len_q <= len_q - 1'b1;
            node_q <= '0;
            top_q <= len_q - 1'b1;
            right_q <= 1'b0;
            root_q <= 1'b1;
            state_q <= S_SW_RD_N;
          end else begin
            build_q <= 1'b0;
            k_q <= '0;
            state_q <= (cnt_q == '0) ? S_LOAD : S_OUT_RD;
          end
        end
        S_RD_TOP: state_q <= S_CAP_TOP;
        // A holds mem[top]; right_q set once the left child has been tested
        S_CAP_TOP: begin
          if (!right_q) begin
            if (left < {1'b0, len_q}) begin
              ch_q <= left[CW-1:0]; state_q <= S_RD_CH;
            end else state_q <= S_NEXT;
          end else if (left + 1'b1 < {1'b0, len_q}) begin
            ch_q <= left[CW-1:0] + 1'b1; state_q <= S_RD_CH;
          end else if (top_q != node_q) begin
            state_q <= S_SW_RD_N;
          end else state_q <= S_NEXT;
        end
        S_RD_CH: state_q <= S_CAP_CH;
        S_CAP_CH: state_q <= S_CMP;
        S_CMP: begin
          if (!right_q) begin
            right_q <= 1'b1;
            if (b_gt_a_i) begin
              top_q <= ch_q;
              state_q <= S_RD_TOP; // reload A with the new top
            end else if (left + 1'b1 < {1'b0, len_q}) begin
              ch_q <= left[CW-1:0] + 1'b1; state_q <= S_RD_CH;
            end else state_q <= S_NEXT;
          end else if (b_gt_a_i || top_q != node_q) begin
            if (b_gt_a_i) top_q <= ch_q;
            state_q <= S_SW_RD_N;
          end else state_q <= S_NEXT;
        end
        S_SW_RD_N: state_q <= S_SW_RD_T;
        S_SW_RD_T: state_q <= S_SW_CAP_T;
        S_SW_CAP_T: state_q <= S_SWAP_T;
        S_SWAP_T: state_q <= S_SWAP_C;
        S_SWAP_C: begin
          node_q <= root_q ? '0 : top_q;
          top_q <= root_q ? '0 : top_q;
          right_q <= 1'b0;
          root_q <= 1'b0;
          state_q <= S_RD_TOP;
        end
        S_OUT_RD: state_q <= S_OUT_SHOW;
        S_OUT_SHOW: if (out_ready_i) begin
          if (k_q + 1'b1 == cnt_q) begin
            cnt_q <= '0; drop_q <= 1'b0; state_q <= S_LOAD;
          end else begin
            k_q <= k_q + 1'b1; state_q <= S_OUT_RD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/heap_sort_engine.sv -----
// heap_sort_engine: top level, heapsort of double keys.
// Depends on hse_pkg, hse_ctrl, hse_datapath.
//
//  channel | valid     | ready     | words
//  in      | in_valid_i| in_ready_o| key_bits_i, last_key_i
//  out     | out_valid_o| out_ready_i| sorted_bits_o, last_sorted_o, keys_dropped_o
//
// Load accepts one word per cycle. Sort runs on one single-port key RAM:
// each sift level reads the top and each child into the key registers for a
// compare, reloads a new top, and swaps via two reads and two writes; each
// sort-down step first swaps the root; read-out reads each word, then shows it.
// Input is stalled from the last key until the final word is taken.
// Reset clears control state only; the RAM needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module heap_sort_engine import hse_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [KeyW-1:0] key_bits_i,
  input  wire logic            last_key_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [KeyW-1:0]      sorted_bits_o,
  output logic                 last_sorted_o,
  output logic                 keys_dropped_o
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  cmd_e            cmd;
  logic [AW-1:0]   addr;
  logic            cap_a, cap_b, b_gt_a, out_sel;
  logic [KeyW-1:0] a_val, rdata;

  hse_ctrl #(.Capacity(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_i(last_key_i), .in_ready_o,
    .out_ready_i, .out_valid_o, .out_last_o(last_sorted_o),
    .out_drop_o(keys_dropped_o), .out_sel_o(out_sel), .cmd_o(cmd), .addr_o(addr),
    .cap_a_o(cap_a), .cap_b_o(cap_b), .b_gt_a_i(b_gt_a)
  );

  hse_datapath #(.Capacity(CAPACITY)) u_dp (
    .clk_i, .cmd_i(cmd), .addr_i(addr), .key_i(key_bits_i),
    .cap_a_i(cap_a), .cap_b_i(cap_b), .a_o(a_val), .b_gt_a_o(b_gt_a), .rdata_o(rdata)
  );

  assign sorted_bits_o = out_sel ? rdata : a_val;
endmodule
`default_nettype wire
